>>> rtl/core/pmu_pkg.sv
// shared types and constants for the park-miller uniform integer core
package pmu_pkg;

  // lehmer recurrence constants
  localparam logic [14:0] LCG_MULT   = 15'd16807;
  localparam logic [30:0] LCG_MOD    = 31'h7FFF_FFFF;
  localparam logic [30:0] SEED_RESET = 31'd123456789;

  // configuration register reset values
  localparam logic [31:0] RANGE_LOW_RESET  = 32'd0;
  localparam logic [31:0] RANGE_HIGH_RESET = 32'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_START = 2'd2;

  // request payload
  typedef struct packed {
    logic draw;
  } pmu_req_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] value;
    logic [30:0]        seed_after;
    logic               seed_error;
  } pmu_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic fold;
    logic mul_lo;
    logic mul_hi;
    logic offset;
    logic load_out;
  } pmu_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic seed_zero;
  } pmu_status_t;

endpackage

>>> rtl/core/pmu_stream_if.sv
// valid/ready stream channel carrying one payload per transfer
interface pmu_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/pmu_ctrl.sv
// sequencing state machine for one draw at a time
module pmu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_draw,
  output logic                req_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pmu_pkg::pmu_status_t status,
  output pmu_pkg::pmu_cmd_t    cmd
);
  import pmu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FOLD = 6'b000010,
    S_PA   = 6'b000100,
    S_PB   = 6'b001000,
    S_OFF  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   start;

  assign req_ready = (state == S_IDLE);
  assign start     = req_valid && req_ready && req_draw;

  // next state and command decode
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.start    = start;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = status.seed_zero ? S_DONE : S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = S_PA;
      end
      S_PA: begin
        cmd.mul_lo = 1'b1;
        state_next = S_PB;
      end
      S_PB: begin
        cmd.mul_hi = 1'b1;
        state_next = S_OFF;
      end
      S_OFF: begin
        cmd.offset = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = !out_valid || out_ready;
        if (cmd.load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a good seed at a draw starts the fold step
  a_start_fold: assert property (@(posedge clk) disable iff (rst)
    start && !status.seed_zero |=> state == S_FOLD)
    else $error("draw with nonzero seed did not enter fold");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // a result appears only after the done step
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result shown without done step");

endmodule

>>> rtl/core/pmu_dp.sv
// seed recurrence, range mapping and output register
module pmu_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pmu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_wdata,
  input  pmu_pkg::pmu_cmd_t           cmd,
  output pmu_pkg::pmu_status_t        status,
  output pmu_pkg::pmu_rsp_t           rsp_data
);
  import pmu_pkg::*;

  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [30:0]        seed_value;

  logic [45:0]        prod;
  logic signed [31:0] lo_ord;
  logic signed [31:0] hi_ord;
  logic               err;
  logic [32:0]        span;
  logic [46:0]        pa;
  logic [47:0]        pb;
  logic [31:0]        off;

  logic [31:0]        fold_sum;
  logic [31:0]        fold_red;
  logic [63:0]        total;
  logic [32:0]        res;

  assign status.seed_zero = (seed_value == '0);

  // mod 2^31-1 fold: high part wraps onto low part, one conditional subtract
  assign fold_sum = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
  assign fold_red = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sum - {1'b0, LCG_MOD} : fold_sum;

  // recombine the two partial products, keep bits 62:31
  assign total = {17'd0, pa} + {pb, 16'd0};
  assign res   = {lo_ord[31], lo_ord} + {1'b0, off};

  // configuration registers and generator state, a seed_start write loads the seed
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
      seed_value <= SEED_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:  range_low  <= cfg_wdata;
          CFG_RANGE_HIGH: range_high <= cfg_wdata;
          CFG_SEED_START: seed_value <= cfg_wdata[30:0];
          default: ;
        endcase
      end else if (cmd.fold) begin
        seed_value <= fold_red[30:0];
      end
    end
  end

  // arithmetic pipeline registers, one step per command
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      prod <= seed_value * LCG_MULT;
      err  <= (seed_value == '0);
      if (range_high < range_low) begin
        lo_ord <= range_high;
        hi_ord <= range_low;
      end else begin
        lo_ord <= range_low;
        hi_ord <= range_high;
      end
    end
    if (cmd.fold) begin
      span <= {hi_ord[31], hi_ord} - {lo_ord[31], lo_ord} + 33'd1;
    end
    if (cmd.mul_lo) begin
      pa <= seed_value * span[15:0];
    end
    if (cmd.mul_hi) begin
      pb <= seed_value * span[32:16];
    end
    if (cmd.offset) begin
      off <= total[62:31];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.value      <= err ? '0 : res[31:0];
      rsp_data.seed_after <= seed_value;
      rsp_data.seed_error <= err;
    end
  end

  // an error result carries zero value and zero seed
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) && rsp_data.seed_error |->
      rsp_data.value == '0 && rsp_data.seed_after == '0)
    else $error("error result with nonzero payload");

endmodule

>>> rtl/core/park_miller_uniform_int_core.sv
// top level: park-miller minimal standard generator mapped into a signed range
// a draw runs the fold, two multiply and offset steps, then the done step loads the result
// a zero seed skips to done; a new draw is taken only when idle, after the result is loaded
// a request with draw low is taken and gives no result
// reset: synchronous, loads bounds 0 and 1 and seed 123456789, marks the output register empty
module park_miller_uniform_int_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pmu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  pmu_stream_if.sink                    req,
  pmu_stream_if.source                  rsp
);
  import pmu_pkg::*;

  pmu_cmd_t    cmd;
  pmu_status_t status;
  pmu_rsp_t    rsp_data;
  pmu_req_t    req_data;
  logic        req_ready;
  logic        out_valid;

  assign req_data  = req.data;
  assign req.ready = req_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_data;

  // controller
  pmu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_draw  (req_data.draw),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  pmu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .rsp_data  (rsp_data)
  );

endmodule
